/* sv/fsat_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the feature score average table.
// No dependencies; every other file imports this package.
package fsat_pkg;

   localparam int NUM_FEATURES = 32;
   localparam int TABLE_DEPTH  = 2 * NUM_FEATURES + 1;
   localparam int ADDR_W       = $clog2(TABLE_DEPTH);
   localparam int FEAT_W       = $clog2(NUM_FEATURES);
   localparam int MASK_W       = 33;
   localparam int AVG_W        = 16;
   localparam int CNT_W        = 24;
   localparam int ENT_W        = 6;
   localparam int OP_W         = 1;
   localparam int IDX_W        = 7;
   localparam int PROD_W       = AVG_W + CNT_W;
   localparam int DIVR_W       = CNT_W + 1;
   localparam int STEP_W       = $clog2(AVG_W + 1);
   localparam int ENTRY_W      = AVG_W + CNT_W;
   localparam int REQ_W        = 64;
   localparam int RSP_W        = 48;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ_ADDR,
      ST_SCAN,
      ST_FETCH,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      ADDR_FEAT,
      ADDR_SUBSET,
      ADDR_READ
   } addr_sel_type;

   typedef enum logic [1:0] {
      RSP_UPDATE,
      RSP_READ,
      RSP_ERROR
   } rsp_kind_type;

   localparam logic OP_UPDATE  = 1'b0;
   localparam logic OP_READ    = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic         capture;
      logic         mem_rd;
      addr_sel_type addr_sel;
      logic         mul_en;
      logic         div_start;
      logic         mem_wr;
      logic         scan_next;
      logic         chosen_inc;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic is_update;
      logic stop_bit;
      logic bit_set;
      logic scan_last;
      logic index_ok;
      logic div_done;
      logic rsp_free;
   } dp_stat_type;

endpackage

/* sv/fsat_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the moving-average fold.
// Depends on fsat_pkg. Quotient must fit in AVG_W bits (guaranteed by the fold).
module fsat_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fsat_pkg::PROD_W-1:0] dividend,
   input  logic [fsat_pkg::DIVR_W-1:0] divisor,
   output logic                       done,
   output logic [fsat_pkg::AVG_W-1:0]  quotient
);
   import fsat_pkg::*;

   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [AVG_W-1:0]  num_ff, num_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   diff;
   logic              qbit;

   assign trial = {rem_ff, num_ff[AVG_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign qbit  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // high part is below the divisor since the quotient fits AVG_W bits
         rem_in  = {1'b0, dividend[PROD_W-1:AVG_W]};
         num_in  = dividend[AVG_W-1:0];
         dvs_in  = divisor;
         cnt_in  = STEP_W'(AVG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         num_in = {num_ff[AVG_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

/* sv/fsat_dp.sv */
`timescale 1ns / 1ps
// Datapath: item registers, score/count memory with valid bits, multiply,
// divider and the result register. Depends on fsat_pkg and fsat_div.
module fsat_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  fsat_pkg::dp_cmd_type        cmd,
   output fsat_pkg::dp_stat_type       stat,
   input  logic [fsat_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fsat_pkg::RSP_W-1:0]  rsp_tdata
);
   import fsat_pkg::*;

   // item registers
   logic [OP_W-1:0]   op_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [AVG_W-1:0]  reward_ff;
   logic [IDX_W-1:0]  ridx_ff;
   logic [FEAT_W-1:0] scan_ff, scan_in;
   logic [ENT_W-1:0]  chosen_ff, chosen_in;

   // table storage
   logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [ENTRY_W-1:0]     q_ff;
   logic                   qv_ff;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [AVG_W-1:0]       q_avg;
   logic [CNT_W-1:0]       q_cnt;

   // fold arithmetic
   logic [PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [AVG_W-1:0]  quot;
   logic              div_done;
   logic [CNT_W-1:0]  cnt_new;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [ENT_W-1:0]  rsp_ent_ff;
   logic [AVG_W-1:0]  rsp_avg_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   assign q_avg = qv_ff ? q_ff[ENTRY_W-1:CNT_W] : '0;
   assign q_cnt = qv_ff ? q_ff[CNT_W-1:0] : '0;

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_FEAT:   addr_in = ADDR_W'(scan_ff);
         ADDR_SUBSET: addr_in = ADDR_W'(NUM_FEATURES) + ADDR_W'(chosen_ff);
         ADDR_READ:   addr_in = ridx_ff[ADDR_W-1:0];
         default:     addr_in = ADDR_W'(scan_ff);
      endcase
   end

   assign scan_in   = cmd.capture ? '0 : (cmd.scan_next ? scan_ff + 1'b1 : scan_ff);
   assign chosen_in = cmd.capture ? '0 : (cmd.chosen_inc ? chosen_ff + 1'b1 : chosen_ff);
   assign cnt_new   = (n_ff == COUNT_MAX) ? n_ff : n_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_tdata[0 +: OP_W];
         mask_ff   <= req_tdata[OP_W +: MASK_W];
         reward_ff <= req_tdata[OP_W+MASK_W +: AVG_W];
         ridx_ff   <= req_tdata[OP_W+MASK_W+AVG_W +: IDX_W];
      end
      scan_ff   <= scan_in;
      chosen_ff <= chosen_in;
      if (cmd.mem_rd) begin
         addr_ff <= addr_in;
         q_ff    <= mem[addr_in];
         qv_ff   <= valid_ff[addr_in];
      end
      if (cmd.mem_wr)
         mem[addr_ff] <= {quot, cnt_new};
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(q_avg * q_cnt) + PROD_W'(reward_ff);
         n_ff    <= q_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (cmd.mem_wr)
         valid_ff[addr_ff] <= 1'b1;
   end

   fsat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  ({1'b0, n_ff} + DIVR_W'(1)),
      .done     (div_done),
      .quotient (quot)
   );

   // result beat
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
      if (cmd.rsp_load) begin
         case (cmd.rsp_kind)
            RSP_UPDATE: begin
               rsp_status_ff <= STATUS_OK;
               rsp_ent_ff    <= chosen_ff + 1'b1;
               rsp_avg_ff    <= '0;
               rsp_cnt_ff    <= '0;
            end
            RSP_READ: begin
               rsp_status_ff <= STATUS_OK;
               rsp_ent_ff    <= '0;
               rsp_avg_ff    <= q_avg;
               rsp_cnt_ff    <= q_cnt;
            end
            default: begin
               rsp_status_ff <= STATUS_ERR;
               rsp_ent_ff    <= '0;
               rsp_avg_ff    <= '0;
               rsp_cnt_ff    <= '0;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_avg_ff, rsp_ent_ff, rsp_status_ff};

   assign stat.is_update = (op_ff == OP_UPDATE);
   assign stat.stop_bit  = mask_ff[NUM_FEATURES];
   assign stat.bit_set   = mask_ff[scan_ff];
   assign stat.scan_last = (scan_ff == FEAT_W'(NUM_FEATURES - 1));
   assign stat.index_ok  = (ridx_ff < IDX_W'(TABLE_DEPTH));
   assign stat.div_done  = div_done;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule

/* sv/fsat_ctrl.sv */
`timescale 1ns / 1ps
// Controller: walks the mask, sequences each fold and the result beat.
// Depends on fsat_pkg; drives fsat_dp through dp_cmd_type.
module fsat_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fsat_pkg::dp_stat_type stat,
   output fsat_pkg::dp_cmd_type  cmd
);
   import fsat_pkg::*;

   state_type    state_ff, state_in;
   logic         sub_ff, sub_in;
   rsp_kind_type kind_ff, kind_in;

   // next state
   always_comb begin
      state_in = state_ff;
      sub_in   = sub_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
               sub_in   = 1'b0;
            end
         end
         ST_DISPATCH: begin
            if (!stat.is_update) begin
               if (stat.index_ok) begin
                  state_in = ST_READ_ADDR;
                  kind_in  = RSP_READ;
               end else begin
                  state_in = ST_RESP;
                  kind_in  = RSP_ERROR;
               end
            end else if (!stat.stop_bit) begin
               state_in = ST_RESP;
               kind_in  = RSP_ERROR;
            end else begin
               state_in = ST_SCAN;
               kind_in  = RSP_UPDATE;
            end
         end
         ST_READ_ADDR: state_in = ST_RESP;
         ST_SCAN: begin
            if (stat.bit_set) begin
               state_in = ST_FETCH;
            end else if (stat.scan_last) begin
               state_in = ST_FETCH;
               sub_in   = 1'b1;
            end
         end
         ST_FETCH:  state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (stat.div_done)
               state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (sub_ff) begin
               state_in = ST_RESP;
            end else if (stat.scan_last) begin
               state_in = ST_FETCH;
               sub_in   = 1'b1;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_RESP: begin
            if (stat.rsp_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.addr_sel = ADDR_FEAT;
      cmd.rsp_kind = kind_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no beat is taken while reset is held
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
         end
         ST_READ_ADDR: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_READ;
         end
         ST_SCAN: begin
            cmd.scan_next = !stat.bit_set && !stat.scan_last;
         end
         ST_FETCH: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = sub_ff ? ADDR_SUBSET : ADDR_FEAT;
         end
         ST_MUL:    cmd.mul_en    = 1'b1;
         ST_DIV_GO: cmd.div_start = 1'b1;
         ST_WRITE: begin
            cmd.mem_wr     = 1'b1;
            cmd.chosen_inc = !sub_ff;
            cmd.scan_next  = !sub_ff && !stat.scan_last;
         end
         ST_RESP:   cmd.rsp_load = stat.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sub_ff   <= 1'b0;
         kind_ff  <= RSP_ERROR;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

/* sv/feature_score_average_table_top.sv */
`timescale 1ns / 1ps
// Top level of the feature score average table: controller plus datapath.
// Depends on fsat_pkg, fsat_ctrl, fsat_dp (which holds fsat_div).
//
// The block keeps 65 entries of {Q0.16 average, 24-bit hit count}: entries
// 0..31 belong to features, entry 32+k to subsets of k chosen features.
// An update beat (op 0) needs the stop marker, mask bit 32, set; otherwise it
// returns status 1 and changes nothing. Each chosen feature and then the
// subset-size entry folds the reward in as avg = floor((avg*n + r)/(n+1)),
// n = n+1, with n held once it reaches 2^24-1; the result carries the number
// of entries touched. A read beat (op 1) returns one entry, or status 1 for
// an index of 65 or more. Items run one at a time. An update scans every
// mask bit and folds each updated entry in turn; each fold is paced by the
// shift-subtract divider. The result sits in an output register, so the
// next request is taken while it waits. No request is taken while reset is
// held. After reset the table reads as all zero at once (per-entry valid
// bits).
module feature_score_average_table_top (
   input  logic                       clock,
   input  logic                       reset,
   // request: [0] op, [33:1] feature_mask, [49:34] reward, [56:50] read_index
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [fsat_pkg::REQ_W-1:0] req_tdata,
   // response: [0] status, [6:1] entries_updated, [22:7] read_average,
   //           [46:23] read_count
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [fsat_pkg::RSP_W-1:0] rsp_tdata
);
   import fsat_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fsat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fsat_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
